[rtl/core/gprd_pkg.sv]
// Shared constants and the packed result layout for the gamepad poll reply decoder.
// No dependencies; imported by the decoder top level and its checker.

package gprd_pkg;

  // Packet and port geometry
  localparam int MAX_PACKET  = 32;
  localparam int PORT_COUNT  = 2;
  localparam int IDX_W       = $clog2(MAX_PACKET + 1);
  // Only the first bytes up to the last pressure byte are ever decoded
  localparam int KEEP_BYTES  = 21;

  // Reply framing constants
  localparam logic [7:0]  REPLY_MARK   = 8'h5A;
  localparam logic [7:0]  ID_NONE      = 8'h00;
  localparam logic [7:0]  ID_FLOAT     = 8'hFF;
  localparam logic [7:0]  SHIFT_FILL   = 8'hFF;
  localparam logic [7:0]  STICK_CENTRE = 8'h80;
  localparam logic [15:0] BUTTON_MASK  = 16'hFFFF;

  // Minimum lengths for each section of the reply
  localparam int MIN_LEN_VALID    = 5;
  localparam int MIN_LEN_STICKS   = 9;
  localparam int MIN_LEN_PRESSURE = 21;

  // Byte positions inside a reply
  localparam int POS_ID       = 1;
  localparam int POS_MARK     = 2;
  localparam int POS_BTN_LO   = 3;
  localparam int POS_BTN_HI   = 4;
  localparam int POS_STICK    = 5;
  localparam int POS_PRES_LO  = 9;
  localparam int POS_PRES_HI  = 17;

  // Result word as carried on the output tdata, connected in bit 0
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] error_count;
    logic [31:0] frame_count;
    logic [31:0] pressure_high;
    logic [63:0] pressure_low;
    logic [7:0]  left_y;
    logic [7:0]  left_x;
    logic [7:0]  right_y;
    logic [7:0]  right_x;
    logic [15:0] buttons;
    logic [7:0]  pad_id;
    logic        connected;
  } gprd_res_t;

  localparam int RES_W = $bits(gprd_res_t);

endpackage

[rtl/core/gamepad_poll_reply_decoder.sv]
// Gamepad poll reply decoder top level: byte capture, reply check and per-port state.
// Depends on gprd_pkg for constants and the result layout.

// Reply bytes are taken one per cycle with no gaps required; the byte marked
// tlast closes the reply, and its decoded port state goes through the capture
// register and then the result register before it appears on the output.
// Replies that fail the check still give a result, with an incremented error
// count. The output register lets a new byte in while a result waits, so the
// input stalls only when both the capture register and the result register
// are full. Bytes past the maximum packet length are dropped and the reply
// length stops at that maximum.
module gamepad_poll_reply_decoder
  import gprd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] data
  input  logic [1:0]       s_axis_tuser,   // [0] port, [1] shifted
  input  logic             s_axis_tlast,   // last byte of the reply
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [RES_W-1:0] m_axis_tdata,   // connected, pad_id, buttons, right_x, right_y,
                                           // left_x, left_y, pressure_low, pressure_high,
                                           // frame_count, error_count, zero fill
  output logic             m_axis_tuser    // [0] port_out
);

  // Handshake control
  logic s_acc;
  logic res_free;
  logic dec_go;

  // Byte capture
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       buf_q [KEEP_BYTES];

  // Capture register for a closed reply
  logic             dec_valid_q;
  logic             dec_port_q;
  logic             dec_shift_q;
  logic [IDX_W-1:0] dec_len_q;

  // Per-port state that outlives a reply; id, buttons and sticks are rebuilt every time
  logic [63:0] plo_q  [PORT_COUNT];
  logic [31:0] phi_q  [PORT_COUNT];
  logic [31:0] frm_q  [PORT_COUNT];
  logic [31:0] err_q  [PORT_COUNT];

  // Decode path
  logic [7:0] pkt [KEEP_BYTES];
  logic       good;
  gprd_res_t  res_d;

  // Result register
  logic       res_valid_q;
  gprd_res_t  res_q;
  logic       res_port_q;

  assign res_free      = !res_valid_q || m_axis_tready;
  assign dec_go        = dec_valid_q && res_free;
  assign s_axis_tready = !dec_valid_q || res_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Byte count saturates at the maximum packet length
  always_comb begin
    if (idx_q < IDX_W'(MAX_PACKET)) begin
      idx_d = idx_q + IDX_W'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      dec_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        idx_q <= s_axis_tlast ? '0 : idx_d;
      end
      if (s_acc && s_axis_tlast) begin
        dec_valid_q <= 1'b1;
      end else if (dec_go) begin
        dec_valid_q <= 1'b0;
      end
    end
  end

  // Closed reply details; payload only
  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tlast) begin
      dec_port_q  <= s_axis_tuser[0];
      dec_shift_q <= s_axis_tuser[1];
      dec_len_q   <= idx_d;
    end
  end

  // Byte store: each slot written only when the count points at it
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < KEEP_BYTES; k++) begin
      if (s_acc && idx_q == IDX_W'(k)) begin
        buf_q[k] <= s_axis_tdata;
      end
    end
  end

  // Reply bytes as seen after the optional one-byte realignment
  always_comb begin
    pkt[0] = dec_shift_q ? SHIFT_FILL : buf_q[0];
    for (int k = 1; k < KEEP_BYTES; k++) begin
      pkt[k] = dec_shift_q ? buf_q[k-1] : buf_q[k];
    end
  end

  // Reply check
  assign good = (dec_len_q >= IDX_W'(MIN_LEN_VALID)) &&
                (pkt[POS_ID] != ID_NONE) && (pkt[POS_ID] != ID_FLOAT) &&
                (pkt[POS_MARK] == REPLY_MARK);

  // Next state of the addressed port, which is also the reported result
  always_comb begin
    res_d               = '0;
    res_d.pressure_low  = plo_q[dec_port_q];
    res_d.pressure_high = phi_q[dec_port_q];
    res_d.frame_count   = frm_q[dec_port_q];
    res_d.error_count   = err_q[dec_port_q];
    res_d.right_x       = STICK_CENTRE;
    res_d.right_y       = STICK_CENTRE;
    res_d.left_x        = STICK_CENTRE;
    res_d.left_y        = STICK_CENTRE;
    if (good) begin
      res_d.connected   = 1'b1;
      res_d.pad_id      = pkt[POS_ID];
      res_d.buttons     = ~{pkt[POS_BTN_HI], pkt[POS_BTN_LO]} & BUTTON_MASK;
      res_d.frame_count = frm_q[dec_port_q] + 32'd1;
      if (dec_len_q >= IDX_W'(MIN_LEN_STICKS)) begin
        res_d.right_x = pkt[POS_STICK];
        res_d.right_y = pkt[POS_STICK+1];
        res_d.left_x  = pkt[POS_STICK+2];
        res_d.left_y  = pkt[POS_STICK+3];
      end
      res_d.pressure_low  = '0;
      res_d.pressure_high = '0;
      if (dec_len_q >= IDX_W'(MIN_LEN_PRESSURE)) begin
        for (int i = 0; i < 8; i++) begin
          res_d.pressure_low[8*i +: 8] = pkt[POS_PRES_LO + i];
        end
        for (int i = 0; i < 4; i++) begin
          res_d.pressure_high[8*i +: 8] = pkt[POS_PRES_HI + i];
        end
      end
    end else begin
      res_d.error_count = err_q[dec_port_q] + 32'd1;
    end
  end

  // Per-port state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        plo_q[p]  <= '0;
        phi_q[p]  <= '0;
        frm_q[p]  <= '0;
        err_q[p]  <= '0;
      end
    end else if (dec_go) begin
      plo_q[dec_port_q]  <= res_d.pressure_low;
      phi_q[dec_port_q]  <= res_d.pressure_high;
      frm_q[dec_port_q]  <= res_d.frame_count;
      err_q[dec_port_q]  <= res_d.error_count;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= dec_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_go) begin
      res_q      <= res_d;
      res_port_q <= dec_port_q;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = res_port_q;

endmodule

[rtl/core/gprd_checker.sv]
// Port-level checks for the gamepad poll reply decoder, bound to its top level.
// Depends on gprd_pkg for the result layout.

module gprd_checker
  import gprd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tlast,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [RES_W-1:0] m_axis_tdata,   // result word, connected in bit 0
  input logic             m_axis_tuser    // [0] port_out
);

  gprd_res_t r;
  logic      in_last_acc;

  assign r           = gprd_res_t'(m_axis_tdata);
  assign in_last_acc = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // A failed reply reports cleared id, buttons and centred sticks
  a_bad_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !r.connected |->
      r.pad_id == ID_NONE && r.buttons == '0 &&
      r.right_x == STICK_CENTRE && r.right_y == STICK_CENTRE &&
      r.left_x == STICK_CENTRE && r.left_y == STICK_CENTRE)
    else $error("failed reply left stale controller state");

  // A good reply never carries an absent or floating id
  a_good_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.connected |-> r.pad_id != ID_NONE && r.pad_id != ID_FLOAT)
    else $error("connected with an invalid id");

  // A fresh result follows a closing byte through the capture and result registers
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_last_acc, 2))
    else $error("result without a closing byte");

endmodule

bind gamepad_poll_reply_decoder gprd_checker u_gprd_checker (.*);
